// ===== rtl/timed_table_linear_interpolator_macros.svh =====
// Assertion macros for the timed table linear interpolator.
// Included by the top-level RTL file, which carries the concurrent assertions; no dependencies.
`ifndef TIMED_TABLE_LINEAR_INTERPOLATOR_MACROS_SVH
`define TIMED_TABLE_LINEAR_INTERPOLATOR_MACROS_SVH
`ifndef SYNTHESIS
// Property checked on every rising clock edge outside reset.
`define TTLI_ASSERT(label, clk, rst_n, prop, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) prop) else $error(msg);
// Condition that must hold in the cycle after a trigger.
`define TTLI_ASSERT_NEXT(label, clk, rst_n, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) else $error(msg);
`else
`define TTLI_ASSERT(label, clk, rst_n, prop, msg)
`define TTLI_ASSERT_NEXT(label, clk, rst_n, ante, cons, msg)
`endif
`endif

// ===== rtl/ttli_pkg.sv =====
// Shared types, codes and a helper function of the timed table linear interpolator.
// No dependencies; used by ttli_arith and the top level.
`default_nettype none
package ttli_pkg;

  // Width of a stored sample and of the internal signed arithmetic.
  localparam int VAL_W   = 48;
  localparam int ARITH_W = 52;
  localparam int CNT_W   = $clog2(2 * ARITH_W + 1);
  localparam int Q_W     = 49;

  // Input item modes.
  localparam logic [1:0] MODE_LOAD  = 2'd0;
  localparam logic [1:0] MODE_QUERY = 2'd1;
  localparam logic [1:0] MODE_CLEAR = 2'd2;

  // Configuration register indexes.
  localparam logic [1:0] CFG_TIME_POS  = 2'd0;
  localparam logic [1:0] CFG_VAL_COUNT = 2'd1;
  localparam logic [1:0] CFG_REPEAT    = 2'd2;

  typedef enum logic [4:0] {
    S_IDLE, S_ZFILL, S_TL, S_T0, S_SPAN, S_REMDIV, S_WALK, S_WALKC, S_MAX, S_MAXC,
    S_KDIV, S_KFIX, S_HOLD, S_SEL, S_TP_RD, S_TN_RD, S_TN_CAP, S_VP_RD, S_VN_RD,
    S_MUL, S_MD, S_OUT
  } state_t;

  typedef enum logic [1:0] {A_IDLE, A_MUL, A_DIV} arith_state_t;

  // Request to the shared multiply/divide unit: trunc(a*b/c), or a/c when mul_en is low.
  typedef struct packed {
    logic                      start;
    logic                      mul_en;
    logic signed [ARITH_W-1:0] a;
    logic signed [ARITH_W-1:0] b;
    logic signed [ARITH_W-1:0] c;
  } arith_req_t;

  // Result: capped quotient magnitude, remainder magnitude and result sign.
  typedef struct packed {
    logic               busy;
    logic               done;
    logic               neg;
    logic [Q_W-1:0]     q;
    logic [ARITH_W-1:0] rem;
  } arith_rsp_t;

  function automatic logic signed [ARITH_W-1:0] sext48(input logic [VAL_W-1:0] x);
    sext48 = {{(ARITH_W-VAL_W){x[VAL_W-1]}}, x};
  endfunction

endpackage
`default_nettype wire

// ===== rtl/ttli_store.sv =====
// Sample store: one write port and one registered read port over rows of fields.
// Fields at or beyond the row width read as zero. Standalone, no package use.
`default_nettype none
module ttli_store #(
  parameter int MAX_ROWS   = 256,
  parameter int ROW_FIELDS = 16
) (
  input  wire logic                              clk,
  input  wire logic                              wr_en,
  input  wire logic [$clog2(MAX_ROWS)-1:0]       wr_row,
  input  wire logic [$clog2(ROW_FIELDS)-1:0]     wr_field,
  input  wire logic [47:0]                       wr_data,
  input  wire logic                              rd_en,
  input  wire logic [$clog2(MAX_ROWS)-1:0]       rd_row,
  input  wire logic [3:0]                        rd_field,
  output logic      [47:0]                       rd_data
);
  localparam int DEPTH = MAX_ROWS * ROW_FIELDS;
  localparam int AW    = $clog2(DEPTH);

  logic [47:0]   mem [DEPTH];
  logic [47:0]   q_r;
  logic          zero_r;
  logic [AW-1:0] wr_addr;
  logic [AW-1:0] rd_addr;

  // Row-major addressing.
  assign wr_addr = AW'(wr_row) * AW'(ROW_FIELDS) + AW'(wr_field);
  assign rd_addr = AW'(rd_row) * AW'(ROW_FIELDS) + AW'(rd_field);

  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem[wr_addr] <= wr_data;
    end
  end

  // Registered read; out-of-row fields are forced to zero.
  always_ff @(posedge clk) begin
    if (rd_en) begin
      q_r    <= mem[rd_addr];
      zero_r <= !(32'(rd_field) < ROW_FIELDS);
    end
  end

  assign rd_data = zero_r ? '0 : q_r;
endmodule
`default_nettype wire

// ===== rtl/ttli_arith.sv =====
// Shared serial arithmetic unit: optional shift-add multiply then restoring divide.
// Depends on ttli_pkg for widths and the request and result types.
`default_nettype none
module ttli_arith (
  input  wire logic                 clk,
  input  wire logic                 rst_n,
  input  wire ttli_pkg::arith_req_t req,
  output ttli_pkg::arith_rsp_t      rsp
);
  localparam int W = ttli_pkg::ARITH_W;

  ttli_pkg::arith_state_t state_r, state_nxt;
  logic [2*W-1:0]               acc_r, acc_nxt;
  logic [W-1:0]                 mc_r, mc_nxt;
  logic [W-1:0]                 dv_r, dv_nxt;
  logic [W-1:0]                 rem_r, rem_nxt;
  logic [ttli_pkg::Q_W-1:0]     q_r, q_nxt;
  logic                         over_r, over_nxt;
  logic                         neg_r, neg_nxt;
  logic                         done_r, done_nxt;
  logic [ttli_pkg::CNT_W-1:0]   cnt_r, cnt_nxt;
  logic [W-1:0]                 am, bm, cm;
  logic [W:0]                   sum;
  logic [W:0]                   r2;
  logic                         ge;

  // Operand magnitudes.
  assign am = req.a[W-1] ? W'(-req.a) : W'(req.a);
  assign bm = req.b[W-1] ? W'(-req.b) : W'(req.b);
  assign cm = req.c[W-1] ? W'(-req.c) : W'(req.c);

  // One multiply step and one divide step.
  assign sum = {1'b0, acc_r[2*W-1:W]} + (acc_r[0] ? {1'b0, mc_r} : '0);
  assign r2  = {rem_r, acc_r[2*W-1]};
  assign ge  = r2 >= {1'b0, dv_r};

  always_comb begin
    state_nxt = state_r;
    acc_nxt   = acc_r;
    mc_nxt    = mc_r;
    dv_nxt    = dv_r;
    rem_nxt   = rem_r;
    q_nxt     = q_r;
    over_nxt  = over_r;
    neg_nxt   = neg_r;
    done_nxt  = 1'b0;
    cnt_nxt   = cnt_r;
    case (state_r)
      ttli_pkg::A_IDLE: begin
        if (req.start) begin
          mc_nxt   = am;
          dv_nxt   = cm;
          neg_nxt  = req.a[W-1] ^ req.b[W-1] ^ req.c[W-1];
          rem_nxt  = '0;
          q_nxt    = '0;
          over_nxt = 1'b0;
          cnt_nxt  = ttli_pkg::CNT_W'(W);
          if (req.mul_en) begin
            acc_nxt   = {{W{1'b0}}, bm};
            state_nxt = ttli_pkg::A_MUL;
          end else begin
            acc_nxt   = {am, {W{1'b0}}};
            state_nxt = ttli_pkg::A_DIV;
          end
        end
      end
      ttli_pkg::A_MUL: begin
        acc_nxt = {sum, acc_r[W-1:1]};
        cnt_nxt = cnt_r - 1'b1;
        if (cnt_r == ttli_pkg::CNT_W'(1)) begin
          cnt_nxt   = ttli_pkg::CNT_W'(2 * W);
          state_nxt = ttli_pkg::A_DIV;
        end
      end
      ttli_pkg::A_DIV: begin
        rem_nxt  = ge ? W'(r2 - {1'b0, dv_r}) : r2[W-1:0];
        over_nxt = over_r | q_r[ttli_pkg::Q_W-1];
        q_nxt    = {q_r[ttli_pkg::Q_W-2:0], ge};
        acc_nxt  = {acc_r[2*W-2:0], 1'b0};
        cnt_nxt  = cnt_r - 1'b1;
        if (cnt_r == ttli_pkg::CNT_W'(1)) begin
          done_nxt  = 1'b1;
          state_nxt = ttli_pkg::A_IDLE;
        end
      end
      default: begin
        state_nxt = ttli_pkg::A_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= ttli_pkg::A_IDLE;
      done_r  <= 1'b0;
    end else begin
      state_r <= state_nxt;
      done_r  <= done_nxt;
    end
  end

  always_ff @(posedge clk) begin
    acc_r  <= acc_nxt;
    mc_r   <= mc_nxt;
    dv_r   <= dv_nxt;
    rem_r  <= rem_nxt;
    q_r    <= q_nxt;
    over_r <= over_nxt;
    neg_r  <= neg_nxt;
    cnt_r  <= cnt_nxt;
  end

  // Quotient magnitude is capped at 2^48.
  assign rsp.busy = state_r != ttli_pkg::A_IDLE;
  assign rsp.done = done_r;
  assign rsp.neg  = neg_r;
  assign rsp.rem  = rem_r;
  assign rsp.q    = (over_r || (q_r[ttli_pkg::Q_W-1] && (|q_r[ttli_pkg::Q_W-2:0])))
                    ? {1'b1, {(ttli_pkg::Q_W-1){1'b0}}} : q_r;
endmodule
`default_nettype wire

// ===== rtl/timed_table_linear_interpolator.sv =====
// Top level of the timed table linear interpolator: sequencer, registers, ports.
// Depends on ttli_pkg, ttli_store, ttli_arith and the assertion macro header.
//
// Usage: items enter on in_valid/in_ready. Mode load writes one row element
// (row_end commits the row), mode clear empties the table, mode query returns
// value_count result items on out_valid/out_ready, in column order, with
// out_last on the final one. Configuration writes go through cfg_valid and
// cfg_ready, which is always high; write them only while the block is idle.
// Timing: one item at a time; in_ready is high only while the sequencer idles.
// When a row commits, its unfilled fields are zeroed one at a time. A query
// reads the last and first row times, walks the search pointer row by row,
// scans all rows and divides when time wraps past the end, divides when a
// negative time is reduced, and per column fetches both values and uses the
// shared serial multiply (52 steps) and divide (one step per dividend bit) unit.
// Reset empties the table and clears pointer and wrap correction; stored
// samples are not cleared. When the receiver stalls, the last result waits
// in the output register while the next item may be taken; a further result
// waits for that register to free.
`default_nettype none
`include "timed_table_linear_interpolator_macros.svh"
module timed_table_linear_interpolator #(
  parameter int MAX_ROWS   = 256,
  parameter int ROW_FIELDS = 16
) (
  input  wire logic        clk,
  input  wire logic        rst_n,
  input  wire logic        in_valid,
  output logic             in_ready,
  input  wire logic [1:0]  in_mode,
  input  wire logic [47:0] in_load_value,
  input  wire logic        in_row_end,
  input  wire logic [47:0] in_query_time,
  output logic             out_valid,
  input  wire logic        out_ready,
  output logic [3:0]       out_column_index,
  output logic [47:0]      out_value,
  output logic             out_last,
  input  wire logic        cfg_valid,
  output logic             cfg_ready,
  input  wire logic [1:0]  cfg_index,
  input  wire logic [3:0]  cfg_data
);
  localparam int RW  = $clog2(MAX_ROWS);
  localparam int NW  = $clog2(MAX_ROWS + 1);
  localparam int FW  = $clog2(ROW_FIELDS);
  localparam int FPW = $clog2(ROW_FIELDS + 1);
  localparam int W   = ttli_pkg::ARITH_W;

  ttli_pkg::state_t state_r, state_nxt;

  logic [3:0]  tpos_r;
  logic [3:0]  vcnt_r;
  logic        rep_r;

  logic [NW-1:0]  rows_r, rows_nxt;
  logic [FPW-1:0] fill_r, fill_nxt, fill_inc;
  logic [RW-1:0]  ptr_r, ptr_nxt, ptr_fix;
  logic [47:0]    wc_r, wc_nxt;

  logic signed [47:0]  t_r, t_nxt;
  logic [47:0]         tl_r, tl_nxt;
  logic [47:0]         t0_r, t0_nxt;
  logic [47:0]         maxt_r, maxt_nxt;
  logic [47:0]         tp_r, tp_nxt;
  logic [47:0]         tn_r, tn_nxt;
  logic [47:0]         vp_r, vp_nxt;
  logic signed [W-1:0] span_r, span_nxt;
  logic signed [W-1:0] tm_r, tm_nxt;
  logic signed [W-1:0] diff_r, diff_nxt;
  logic signed [W-1:0] g_r, g_nxt;
  logic signed [W-1:0] d_r, d_nxt;
  logic [NW-1:0]       j_r, j_nxt;
  logic                second_r, second_nxt;
  logic [RW-1:0]       p_r, p_nxt;
  logic [RW-1:0]       nx_r, nx_nxt;
  logic [3:0]          i_r, i_nxt;

  logic                out_valid_r;
  logic [3:0]          out_col_r;
  logic [47:0]         out_value_r;
  logic                out_last_r;
  logic                out_load;

  logic                wr_en;
  logic [RW-1:0]       wr_row;
  logic [FW-1:0]       wr_field;
  logic [47:0]         wr_data;
  logic                rd_en;
  logic [RW-1:0]       rd_row;
  logic [3:0]          rd_field;
  logic [47:0]         rd_data;

  ttli_pkg::arith_req_t arith_req;
  ttli_pkg::arith_rsp_t arith_rsp;

  logic                full;
  logic [RW-1:0]       last_row;
  logic [3:0]          col;
  logic signed [W-1:0] span_c;
  logic signed [W-1:0] tm_c;
  logic signed [W-1:0] kspan;
  logic signed [W-1:0] qv;
  logic signed [W-1:0] sum_v;
  logic [47:0]         sat_v;

  ttli_store #(.MAX_ROWS(MAX_ROWS), .ROW_FIELDS(ROW_FIELDS)) u_store (
    .clk      (clk),
    .wr_en    (wr_en),
    .wr_row   (wr_row),
    .wr_field (wr_field),
    .wr_data  (wr_data),
    .rd_en    (rd_en),
    .rd_row   (rd_row),
    .rd_field (rd_field),
    .rd_data  (rd_data)
  );

  ttli_arith u_arith (
    .clk   (clk),
    .rst_n (rst_n),
    .req   (arith_req),
    .rsp   (arith_rsp)
  );

  // Helper values used by several states.
  assign full     = rows_r == NW'(MAX_ROWS);
  assign last_row = RW'(rows_r - NW'(1));
  assign fill_inc = (32'(fill_r) < ROW_FIELDS) ? fill_r + FPW'(1) : fill_r;
  assign ptr_fix  = (NW'(ptr_r) >= rows_r) ? '0 : ptr_r;
  assign col      = (i_r >= tpos_r) ? i_r + 4'd1 : i_r;
  assign span_c   = ttli_pkg::sext48(tl_r) - ttli_pkg::sext48(rd_data);
  assign tm_c     = ttli_pkg::sext48(t_r) - ttli_pkg::sext48(wc_r);
  assign kspan    = diff_r + g_r;
  assign qv       = W'(arith_rsp.q);
  assign sum_v    = ttli_pkg::sext48(vp_r) + d_r;

  // Saturate the interpolated value to 48 bits.
  always_comb begin
    if (sum_v > ttli_pkg::sext48(48'h7FFF_FFFF_FFFF)) begin
      sat_v = 48'h7FFF_FFFF_FFFF;
    end else if (sum_v < ttli_pkg::sext48(48'h8000_0000_0000)) begin
      sat_v = 48'h8000_0000_0000;
    end else begin
      sat_v = sum_v[47:0];
    end
  end

  assign out_load  = (state_r == ttli_pkg::S_OUT) && (!out_valid_r || out_ready);
  assign in_ready  = state_r == ttli_pkg::S_IDLE;
  assign cfg_ready = 1'b1;

  // Sequencer: next state, datapath updates and memory/arithmetic requests.
  always_comb begin
    state_nxt  = state_r;
    rows_nxt   = rows_r;
    fill_nxt   = fill_r;
    ptr_nxt    = ptr_r;
    wc_nxt     = wc_r;
    t_nxt      = t_r;
    tl_nxt     = tl_r;
    t0_nxt     = t0_r;
    maxt_nxt   = maxt_r;
    tp_nxt     = tp_r;
    tn_nxt     = tn_r;
    vp_nxt     = vp_r;
    span_nxt   = span_r;
    tm_nxt     = tm_r;
    diff_nxt   = diff_r;
    g_nxt      = g_r;
    d_nxt      = d_r;
    j_nxt      = j_r;
    second_nxt = second_r;
    p_nxt      = p_r;
    nx_nxt     = nx_r;
    i_nxt      = i_r;
    wr_en      = 1'b0;
    wr_row     = rows_r[RW-1:0];
    wr_field   = fill_r[FW-1:0];
    wr_data    = in_load_value;
    rd_en      = 1'b0;
    rd_row     = p_r;
    rd_field   = tpos_r;
    arith_req  = '0;
    case (state_r)
      ttli_pkg::S_IDLE: begin
        if (in_valid) begin
          case (in_mode)
            ttli_pkg::MODE_LOAD: begin
              if (!full) begin
                wr_en = (32'(fill_r) <= 32'(vcnt_r)) && (32'(fill_r) < ROW_FIELDS);
                fill_nxt = fill_inc;
              end
              if (in_row_end) begin
                fill_nxt = '0;
                if (!full) begin
                  if (32'(fill_inc) < ROW_FIELDS) begin
                    fill_nxt  = fill_inc;
                    state_nxt = ttli_pkg::S_ZFILL;
                  end else begin
                    rows_nxt = rows_r + NW'(1);
                  end
                end
              end
            end
            ttli_pkg::MODE_QUERY: begin
              if (rows_r != '0 && vcnt_r != 4'd0) begin
                t_nxt     = in_query_time;
                state_nxt = ttli_pkg::S_TL;
              end
            end
            ttli_pkg::MODE_CLEAR: begin
              rows_nxt = '0;
              fill_nxt = '0;
              ptr_nxt  = '0;
              wc_nxt   = '0;
            end
            default: begin
            end
          endcase
        end
      end
      // Zero the rest of the committed row, one field a cycle.
      ttli_pkg::S_ZFILL: begin
        wr_en   = 1'b1;
        wr_data = '0;
        if (32'(fill_r) == ROW_FIELDS - 1) begin
          fill_nxt  = '0;
          rows_nxt  = rows_r + NW'(1);
          state_nxt = ttli_pkg::S_IDLE;
        end else begin
          fill_nxt = fill_r + FPW'(1);
        end
      end
      ttli_pkg::S_TL: begin
        rd_en     = 1'b1;
        rd_row    = last_row;
        state_nxt = ttli_pkg::S_T0;
      end
      // Last time is in; hold the last row when past the end without repeat.
      ttli_pkg::S_T0: begin
        tl_nxt = rd_data;
        rd_en  = 1'b1;
        rd_row = '0;
        if (!rep_r && (t_r > $signed(rd_data))) begin
          p_nxt     = last_row;
          nx_nxt    = last_row;
          tm_nxt    = ttli_pkg::sext48(rd_data);
          state_nxt = ttli_pkg::S_TP_RD;
        end else begin
          state_nxt = ttli_pkg::S_SPAN;
        end
      end
      ttli_pkg::S_SPAN: begin
        t0_nxt     = rd_data;
        span_nxt   = span_c;
        tm_nxt     = tm_c;
        ptr_nxt    = ptr_fix;
        second_nxt = 1'b0;
        j_nxt      = NW'(ptr_fix);
        state_nxt  = ttli_pkg::S_WALK;
        if (tm_c < 0) begin
          if (span_c == 0) begin
            state_nxt = ttli_pkg::S_HOLD;
          end else begin
            arith_req.start = 1'b1;
            arith_req.a     = ttli_pkg::sext48(t_r);
            arith_req.c     = span_c;
            ptr_nxt         = '0;
            j_nxt           = '0;
            state_nxt       = ttli_pkg::S_REMDIV;
          end
        end
      end
      // Remainder of a negative time takes the sign of the time.
      ttli_pkg::S_REMDIV: begin
        if (arith_rsp.done) begin
          tm_nxt    = t_r[47] ? -W'(arith_rsp.rem) : W'(arith_rsp.rem);
          state_nxt = ttli_pkg::S_WALK;
        end
      end
      // Pointer walk: advance while the time lies beyond the row time.
      ttli_pkg::S_WALK: begin
        if (j_r < rows_r) begin
          rd_en     = 1'b1;
          rd_row    = j_r[RW-1:0];
          state_nxt = ttli_pkg::S_WALKC;
        end else if (second_r) begin
          ptr_nxt   = '0;
          state_nxt = ttli_pkg::S_SEL;
        end else if (span_r <= 0) begin
          state_nxt = ttli_pkg::S_HOLD;
        end else begin
          maxt_nxt  = t0_r;
          j_nxt     = NW'(1);
          state_nxt = ttli_pkg::S_MAX;
        end
      end
      ttli_pkg::S_WALKC: begin
        if (tm_r > ttli_pkg::sext48(rd_data)) begin
          j_nxt     = j_r + NW'(1);
          state_nxt = ttli_pkg::S_WALK;
        end else begin
          ptr_nxt   = j_r[RW-1:0];
          state_nxt = ttli_pkg::S_SEL;
        end
      end
      // Scan for the largest row time, then divide the overshoot by the span.
      ttli_pkg::S_MAX: begin
        if (j_r < rows_r) begin
          rd_en     = 1'b1;
          rd_row    = j_r[RW-1:0];
          state_nxt = ttli_pkg::S_MAXC;
        end else begin
          diff_nxt        = tm_r - ttli_pkg::sext48(maxt_r);
          arith_req.start = 1'b1;
          arith_req.a     = tm_r - ttli_pkg::sext48(maxt_r);
          arith_req.c     = span_r;
          state_nxt       = ttli_pkg::S_KDIV;
        end
      end
      ttli_pkg::S_MAXC: begin
        if ($signed(rd_data) > $signed(maxt_r)) begin
          maxt_nxt = rd_data;
        end
        j_nxt     = j_r + NW'(1);
        state_nxt = ttli_pkg::S_MAX;
      end
      ttli_pkg::S_KDIV: begin
        if (arith_rsp.done) begin
          g_nxt     = (arith_rsp.rem == '0) ? '0 : span_r - W'(arith_rsp.rem);
          state_nxt = ttli_pkg::S_KFIX;
        end
      end
      // Subtract whole spans and add them to the wrap correction.
      ttli_pkg::S_KFIX: begin
        tm_nxt     = ttli_pkg::sext48(maxt_r) - g_r;
        wc_nxt     = wc_r + kspan[47:0];
        j_nxt      = '0;
        second_nxt = 1'b1;
        state_nxt  = ttli_pkg::S_WALK;
      end
      ttli_pkg::S_HOLD: begin
        ptr_nxt   = '0;
        p_nxt     = '0;
        nx_nxt    = '0;
        state_nxt = ttli_pkg::S_TP_RD;
      end
      ttli_pkg::S_SEL: begin
        nx_nxt    = ptr_r;
        p_nxt     = (ptr_r != '0) ? ptr_r - RW'(1) : '0;
        state_nxt = ttli_pkg::S_TP_RD;
      end
      // Fetch the two bracketing row times.
      ttli_pkg::S_TP_RD: begin
        rd_en     = 1'b1;
        rd_row    = p_r;
        i_nxt     = '0;
        state_nxt = ttli_pkg::S_TN_RD;
      end
      ttli_pkg::S_TN_RD: begin
        tp_nxt    = rd_data;
        rd_en     = 1'b1;
        rd_row    = nx_r;
        state_nxt = ttli_pkg::S_TN_CAP;
      end
      ttli_pkg::S_TN_CAP: begin
        tn_nxt    = rd_data;
        state_nxt = ttli_pkg::S_VP_RD;
      end
      // Per column: fetch both values, then interpolate.
      ttli_pkg::S_VP_RD: begin
        rd_en     = 1'b1;
        rd_row    = p_r;
        rd_field  = col;
        state_nxt = ttli_pkg::S_VN_RD;
      end
      ttli_pkg::S_VN_RD: begin
        vp_nxt    = rd_data;
        rd_en     = 1'b1;
        rd_row    = nx_r;
        rd_field  = col;
        state_nxt = ttli_pkg::S_MUL;
      end
      ttli_pkg::S_MUL: begin
        if (tn_r == tp_r) begin
          d_nxt     = '0;
          state_nxt = ttli_pkg::S_OUT;
        end else begin
          arith_req.start  = 1'b1;
          arith_req.mul_en = 1'b1;
          arith_req.a      = tm_r - ttli_pkg::sext48(tp_r);
          arith_req.b      = ttli_pkg::sext48(rd_data) - ttli_pkg::sext48(vp_r);
          arith_req.c      = ttli_pkg::sext48(tn_r) - ttli_pkg::sext48(tp_r);
          state_nxt        = ttli_pkg::S_MD;
        end
      end
      ttli_pkg::S_MD: begin
        if (arith_rsp.done) begin
          d_nxt     = arith_rsp.neg ? -qv : qv;
          state_nxt = ttli_pkg::S_OUT;
        end
      end
      ttli_pkg::S_OUT: begin
        if (out_load) begin
          if (i_r == vcnt_r - 4'd1) begin
            state_nxt = ttli_pkg::S_IDLE;
          end else begin
            i_nxt     = i_r + 4'd1;
            state_nxt = ttli_pkg::S_VP_RD;
          end
        end
      end
      default: begin
        state_nxt = ttli_pkg::S_IDLE;
      end
    endcase
  end

  // State and control registers.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= ttli_pkg::S_IDLE;
      rows_r      <= '0;
      fill_r      <= '0;
      ptr_r       <= '0;
      wc_r        <= '0;
      out_valid_r <= 1'b0;
      tpos_r      <= 4'd0;
      vcnt_r      <= 4'd1;
      rep_r       <= 1'b1;
    end else begin
      state_r <= state_nxt;
      rows_r  <= rows_nxt;
      fill_r  <= fill_nxt;
      ptr_r   <= ptr_nxt;
      wc_r    <= wc_nxt;
      if (out_load) begin
        out_valid_r <= 1'b1;
      end else if (out_ready) begin
        out_valid_r <= 1'b0;
      end
      if (cfg_valid) begin
        case (cfg_index)
          ttli_pkg::CFG_TIME_POS:  tpos_r <= cfg_data;
          ttli_pkg::CFG_VAL_COUNT: vcnt_r <= cfg_data;
          ttli_pkg::CFG_REPEAT:    rep_r  <= cfg_data[0];
          default: begin
          end
        endcase
      end
    end
  end

  // Working registers of the current item.
  always_ff @(posedge clk) begin
    t_r      <= t_nxt;
    tl_r     <= tl_nxt;
    t0_r     <= t0_nxt;
    maxt_r   <= maxt_nxt;
    tp_r     <= tp_nxt;
    tn_r     <= tn_nxt;
    vp_r     <= vp_nxt;
    span_r   <= span_nxt;
    tm_r     <= tm_nxt;
    diff_r   <= diff_nxt;
    g_r      <= g_nxt;
    d_r      <= d_nxt;
    j_r      <= j_nxt;
    second_r <= second_nxt;
    p_r      <= p_nxt;
    nx_r     <= nx_nxt;
    i_r      <= i_nxt;
    if (out_load) begin
      out_col_r   <= i_r;
      out_value_r <= sat_v;
      out_last_r  <= i_r == vcnt_r - 4'd1;
    end
  end

  assign out_valid        = out_valid_r;
  assign out_column_index = out_col_r;
  assign out_value        = out_value_r;
  assign out_last         = out_last_r;

  // The arithmetic unit must be free whenever a new item can enter.
  `TTLI_ASSERT(a_unit_idle, clk, rst_n, in_ready |-> !arith_rsp.busy, "unit busy while idle")
  // A finished operation only arrives while the sequencer waits for one.
  `TTLI_ASSERT(a_done_wait, clk, rst_n, arith_rsp.done |-> (state_r == ttli_pkg::S_REMDIV || state_r == ttli_pkg::S_KDIV || state_r == ttli_pkg::S_MD), "unexpected unit result")
  // The row count never exceeds the table capacity.
  `TTLI_ASSERT(a_rows_cap, clk, rst_n, rows_r <= NW'(MAX_ROWS), "row count overflow")
  // The search pointer names a loaded row or the first row.
  `TTLI_ASSERT(a_ptr_range, clk, rst_n, (ptr_r == '0) || (NW'(ptr_r) < rows_r), "pointer out of range")
endmodule
`default_nettype wire

// ===== tb/sv/tb_top.sv =====
// Self-checking testbench for the timed table linear interpolator.
// Depends on ttli_pkg and the timed_table_linear_interpolator RTL; a bit-exact
// interpolation predictor checks each result item against the block's output.
`default_nettype none
module tb_top;
  timeunit 1ns;
  timeprecision 1ps;

  localparam int NROWS = 256;
  localparam int NFIELDS = 16;
  localparam logic [1:0] MODE_UNUSED = 2'd3;
  localparam longint MAXV = 64'sh7FFF_FFFF_FFFF;
  localparam longint MINV = -64'sh8000_0000_0000;

  logic clk;
  logic rst_n;
  logic in_valid, in_ready;
  logic [1:0] in_mode;
  logic [47:0] in_load_value, in_query_time;
  logic in_row_end;
  logic out_valid, out_ready;
  logic [3:0] out_column_index;
  logic [47:0] out_value;
  logic out_last;
  logic cfg_valid, cfg_ready;
  logic [1:0] cfg_index;
  logic [3:0] cfg_data;

  timed_table_linear_interpolator dut (
    .clk(clk), .rst_n(rst_n),
    .in_valid(in_valid), .in_ready(in_ready), .in_mode(in_mode),
    .in_load_value(in_load_value), .in_row_end(in_row_end),
    .in_query_time(in_query_time),
    .out_valid(out_valid), .out_ready(out_ready),
    .out_column_index(out_column_index), .out_value(out_value), .out_last(out_last),
    .cfg_valid(cfg_valid), .cfg_ready(cfg_ready), .cfg_index(cfg_index),
    .cfg_data(cfg_data)
  );

  typedef struct {
    logic [3:0]  col;
    logic [47:0] val;
    logic        lst;
  } column_result_t;

  typedef struct {
    logic [1:0]  mode;
    logic [47:0] ld;
    logic        re;
    logic [47:0] qt;
    bit          chk;
    logic [47:0] ev;
  } stim_row_t;

  // Predictor state: the table, its fill counters, search pointer and wrap correction.
  longint      samples [NROWS*NFIELDS];
  int unsigned n_rows, fill_pos, ptr;
  longint      wrap_corr;
  int unsigned time_col, n_values;
  bit          repeat_on;

  column_result_t pending_results [$];
  stim_row_t      directed [$];
  int  mismatches;
  bit  hold_receiver;

  function automatic longint sx48(logic [47:0] v);
    return longint'(signed'(v));
  endfunction

  function automatic longint sample_at(int unsigned row, int unsigned f);
    if (f >= NFIELDS || row >= NROWS) return 0;
    return samples[row*NFIELDS + f];
  endfunction

  // Exact trunc(a*b/c), magnitude capped at 2^48.
  function automatic longint scaled_delta(longint a, longint b, longint c);
    logic [127:0] ua, ub, uc, q;
    bit neg;
    ua = (a < 0) ? 128'(-a) : 128'(a);
    ub = (b < 0) ? 128'(-b) : 128'(b);
    uc = (c < 0) ? 128'(-c) : 128'(c);
    neg = (a < 0) ^ (b < 0) ^ (c < 0);
    q = (ua * ub) / uc;
    if (q > (128'd1 << 48)) q = 128'd1 << 48;
    return neg ? -longint'(q[63:0]) : longint'(q[63:0]);
  endfunction

  // Applies one accepted item to the predictor and queues the columns it yields.
  task automatic interpolate_item(logic [1:0] mode, logic [47:0] ld, logic re,
                                  logic [47:0] qt);
    int unsigned last_row, p, nx, j;
    longint t, tm, tl, tp, tn, span, maxt, diff, k, vp, vn, d, r;
    bit hold;
    column_result_t res;
    if (mode == ttli_pkg::MODE_LOAD) begin
      if (n_rows < NROWS) begin
        if (fill_pos <= n_values && fill_pos < NFIELDS)
          samples[n_rows*NFIELDS + fill_pos] = sx48(ld);
        if (fill_pos < NFIELDS) fill_pos++;
        if (re) begin
          for (int i = fill_pos; i < NFIELDS; i++) samples[n_rows*NFIELDS + i] = 0;
          n_rows++;
        end
      end
      if (re) fill_pos = 0;
      return;
    end
    if (mode == ttli_pkg::MODE_CLEAR) begin
      n_rows = 0;
      fill_pos = 0;
      ptr = 0;
      wrap_corr = 0;
      return;
    end
    if (mode != ttli_pkg::MODE_QUERY || n_rows == 0 || n_values == 0) return;
    last_row = n_rows - 1;
    tl = sample_at(last_row, time_col);
    t = sx48(qt);
    if (!repeat_on && t > tl) begin
      p = last_row;
      nx = last_row;
      tm = tl;
    end else begin
      span = tl - sample_at(0, time_col);
      hold = 0;
      tm = t - wrap_corr;
      if (ptr >= n_rows) ptr = 0;
      // Negative corrected time folds back into the first period.
      if (tm < 0) begin
        if (span == 0) hold = 1;
        else begin
          tm = t % span;
          ptr = 0;
        end
      end
      if (!hold) begin
        j = ptr;
        while (j < n_rows && tm > sample_at(j, time_col)) j++;
        if (j < n_rows) ptr = j;
        else if (span <= 0) hold = 1;
        else begin
          // Past the end: subtract whole spans and grow the correction.
          maxt = sample_at(0, time_col);
          for (int unsigned m = 1; m < n_rows; m++)
            if (sample_at(m, time_col) > maxt) maxt = sample_at(m, time_col);
          diff = tm - maxt;
          k = (diff <= span) ? 1 : (diff + span - 1) / span;
          tm -= k * span;
          wrap_corr = sx48(48'(wrap_corr + k * span));
          j = 0;
          while (j < n_rows && tm > sample_at(j, time_col)) j++;
          ptr = (j < n_rows) ? j : 0;
        end
      end
      if (hold) begin
        ptr = 0;
        p = 0;
        nx = 0;
      end else begin
        nx = ptr;
        p = (nx != 0) ? nx - 1 : nx;
      end
    end
    tp = sample_at(p, time_col);
    tn = sample_at(nx, time_col);
    for (int unsigned i = 0; i < n_values; i++) begin
      int unsigned col;
      col = (i >= time_col) ? i + 1 : i;
      vp = sample_at(p, col);
      vn = sample_at(nx, col);
      d = 0;
      if (tn != tp) d = scaled_delta(tm - tp, vn - vp, tn - tp);
      r = vp + d;
      if (r > MAXV) r = MAXV;
      if (r < MINV) r = MINV;
      res.col = 4'(i);
      res.val = r[47:0];
      res.lst = (i + 1 == n_values);
      pending_results.push_back(res);
    end
  endtask

  // Clock.
  initial begin
    clk = 0;
    forever #2 clk = ~clk;
  end

  // Run limit.
  initial begin
    #40ms;
    $display("** timed_table_linear_interpolator: FAILED **");
    $finish;
  end

  // Result checker: each accepted result item against the oldest expectation.
  always @(posedge clk) begin
    column_result_t e;
    if (rst_n && out_valid && out_ready) begin
      if (pending_results.size() == 0) begin
        mismatches++;
        if (mismatches <= 10)
          $display("unexpected result item: expected none, got col %0d value %h last %b",
                   out_column_index, out_value, out_last);
      end else begin
        e = pending_results.pop_front();
        if (out_column_index !== e.col || out_value !== e.val || out_last !== e.lst) begin
          mismatches++;
          if (mismatches <= 10)
            $display("result mismatch: expected col %0d value %h last %b, got %0d %h %b",
                     e.col, e.val, e.lst, out_column_index, out_value, out_last);
        end
      end
    end
  end

  // Receiver: random stalls, with one long hold-off on request.
  initial begin
    out_ready = 0;
    forever begin
      @(negedge clk);
      if (hold_receiver) begin
        out_ready <= 0;
        repeat (3000) @(negedge clk);
        hold_receiver = 0;
      end
      if ($urandom_range(0, 3) == 0) begin
        out_ready <= 0;
        repeat (($urandom_range(0, 9) == 0) ? $urandom_range(20, 80)
                                            : $urandom_range(1, 3)) @(negedge clk);
      end
      out_ready <= 1;
      repeat ($urandom_range(1, 12)) @(negedge clk);
    end
  end

  // Offers one item; valid stays high after acceptance until the next item or an idle
  // stretch replaces it, so back-to-back items see a single update per edge.
  task automatic send_item(logic [1:0] mode, logic [47:0] ld, logic re, logic [47:0] qt,
                           bit gaps);
    if (gaps && $urandom_range(0, 2) == 0) begin
      in_valid <= 0;
      repeat (($urandom_range(0, 15) == 0) ? $urandom_range(15, 60)
                                           : $urandom_range(1, 3)) @(negedge clk);
    end
    in_valid <= 1;
    in_mode <= mode;
    in_load_value <= ld;
    in_row_end <= re;
    in_query_time <= qt;
    do @(posedge clk); while (!in_ready);
    interpolate_item(mode, ld, re, qt);
    @(negedge clk);
  endtask

  // Wait until the block is idle, then write one register.
  task automatic write_reg(logic [1:0] idx, logic [3:0] data);
    in_valid <= 0;
    while (pending_results.size() != 0) @(negedge clk);
    repeat (40) @(negedge clk);
    cfg_valid <= 1;
    cfg_index <= idx;
    cfg_data <= data;
    do @(posedge clk); while (!cfg_ready);
    case (idx)
      ttli_pkg::CFG_TIME_POS:  time_col = data;
      ttli_pkg::CFG_VAL_COUNT: n_values = data;
      ttli_pkg::CFG_REPEAT:    repeat_on = data[0];
      default: ;
    endcase
    @(negedge clk);
    cfg_valid <= 0;
  endtask

  task automatic add_row(logic [1:0] mode, logic [47:0] ld, logic re, logic [47:0] qt,
                         bit chk, logic [47:0] ev);
    stim_row_t s;
    s = '{mode, ld, re, qt, chk, ev};
    directed.push_back(s);
  endtask

  function automatic logic [47:0] rand48();
    return {$urandom(), $urandom()};
  endfunction

  // Stimulus.
  initial begin
    int items, n_tab, vc, nq, qbefore, waited;
    longint tcur, tend;
    logic [47:0] qtime;
    logic [47:0] got;
    rst_n = 0;
    in_valid = 0;
    in_mode = ttli_pkg::MODE_LOAD;
    in_load_value = '0;
    in_row_end = 0;
    in_query_time = '0;
    cfg_valid = 0;
    cfg_index = ttli_pkg::CFG_TIME_POS;
    cfg_data = '0;
    mismatches = 0;
    hold_receiver = 0;
    n_rows = 0; fill_pos = 0; ptr = 0; wrap_corr = 0;
    time_col = 0; n_values = 1; repeat_on = 1;
    foreach (samples[i]) samples[i] = 0;
    repeat (9) @(negedge clk);
    rst_n <= 1;

    // Directed table: two value columns, time first, repeat on.
    write_reg(ttli_pkg::CFG_VAL_COUNT, 4'd2);
    write_reg(ttli_pkg::CFG_TIME_POS, 4'd0);
    write_reg(ttli_pkg::CFG_REPEAT, 4'd1);
    add_row(ttli_pkg::MODE_CLEAR, '0, 0, '0, 0, '0);
    add_row(ttli_pkg::MODE_QUERY, '0, 0, 48'h1_0000, 0, '0);             // empty table
    add_row(ttli_pkg::MODE_LOAD, 48'h0, 0, '0, 0, '0);
    add_row(ttli_pkg::MODE_LOAD, 48'h7FFF_FFFF_FFFF, 0, '0, 0, '0);
    add_row(ttli_pkg::MODE_LOAD, 48'h8000_0000_0000, 1, '0, 0, '0);
    add_row(ttli_pkg::MODE_QUERY, '0, 0, 48'h0, 1, 48'h7FFF_FFFF_FFFF);  // single row
    add_row(ttli_pkg::MODE_LOAD, 48'h1_0000, 0, '0, 0, '0);
    add_row(ttli_pkg::MODE_LOAD, 48'h8000_0000_0000, 0, '0, 0, '0);
    add_row(ttli_pkg::MODE_LOAD, 48'h0, 0, '0, 0, '0);
    add_row(ttli_pkg::MODE_LOAD, 48'h1234_5678_9ABC, 1, '0, 0, '0);      // extra element
    add_row(ttli_pkg::MODE_QUERY, '0, 0, 48'h8000, 0, '0);
    add_row(ttli_pkg::MODE_QUERY, '0, 0, 48'hFFFF_FFFF_8000, 0, '0);     // negative time
    add_row(ttli_pkg::MODE_QUERY, '0, 0, 48'h3_4000, 0, '0);             // wrap past end
    add_row(ttli_pkg::MODE_QUERY, '0, 0, 48'h7FFF_FFFF_FFFF, 0, '0);
    add_row(ttli_pkg::MODE_QUERY, '0, 0, 48'h8000_0000_0000, 0, '0);
    add_row(MODE_UNUSED, rand48(), 1, rand48(), 0, '0);
    add_row(ttli_pkg::MODE_LOAD, 48'h5_0000, 1, '0, 0, '0);              // short row
    add_row(ttli_pkg::MODE_QUERY, '0, 0, 48'h4_0000, 0, '0);
    add_row(ttli_pkg::MODE_CLEAR, '0, 0, '0, 0, '0);
    add_row(ttli_pkg::MODE_LOAD, 48'h2_0000, 0, '0, 0, '0);
    add_row(ttli_pkg::MODE_LOAD, 48'h0000_0001_0000, 1, '0, 0, '0);
    add_row(ttli_pkg::MODE_LOAD, 48'h2_0000, 0, '0, 0, '0);
    add_row(ttli_pkg::MODE_LOAD, 48'h0000_0005_0000, 1, '0, 0, '0);      // zero span
    add_row(ttli_pkg::MODE_QUERY, '0, 0, 48'hFFFF_FFFF_0000, 1, 48'h1_0000);
    foreach (directed[i]) begin
      qbefore = pending_results.size();
      send_item(directed[i].mode, directed[i].ld, directed[i].re, directed[i].qt, 1);
      if (directed[i].chk) begin
        got = (pending_results.size() <= qbefore) ? 'x : pending_results[qbefore].val;
        if (got !== directed[i].ev) begin
          mismatches++;
          if (mismatches <= 10)
            $display("directed row %0d: expected value %h, predicted %h",
                     i, directed[i].ev, got);
        end
      end
    end
    write_reg(ttli_pkg::CFG_REPEAT, 4'd0);
    send_item(ttli_pkg::MODE_QUERY, '0, 0, 48'h9_0000, 1);               // hold last row
    write_reg(ttli_pkg::CFG_VAL_COUNT, 4'd0);
    send_item(ttli_pkg::MODE_QUERY, '0, 0, 48'h1_0000, 1);               // no value columns

    // Random phases: a configuration, a fresh table, then a run of queries.
    items = 0;
    for (int ph = 0; items < 380; ph++) begin
      vc = ($urandom_range(0, 7) == 0) ? $urandom_range(0, 15) : $urandom_range(1, 4);
      write_reg(ttli_pkg::CFG_VAL_COUNT, 4'(vc));
      write_reg(ttli_pkg::CFG_TIME_POS, ($urandom_range(0, 7) == 0)
                ? 4'($urandom_range(0, 15)) : 4'($urandom_range(0, vc)));
      write_reg(ttli_pkg::CFG_REPEAT, 4'($urandom_range(0, 1)));
      send_item(ttli_pkg::MODE_CLEAR, rand48(), 1'($urandom_range(0, 1)), rand48(), 1);
      n_tab = $urandom_range(1, 6);
      tcur = $urandom_range(0, 1) ? 0 : longint'($urandom_range(0, 8)) <<< 16;
      for (int r = 0; r < n_tab; r++) begin
        int nel;
        nel = ($urandom_range(0, 9) == 0) ? $urandom_range(1, 17) : vc + 1;
        // A time field past the value columns is left unwritten: such rows stop at vc + 1 elements.
        if (int'(time_col) > vc && nel > vc + 1) nel = vc + 1;
        for (int e = 0; e < nel; e++) begin
          logic [47:0] v;
          if (e == time_col)
            v = ($urandom_range(0, 15) == 0) ? rand48() : tcur[47:0];
          else
            v = ($urandom_range(0, 1) == 0) ? rand48() : 48'($urandom_range(0, 1 << 20));
          send_item(ttli_pkg::MODE_LOAD, v, e == nel - 1, rand48(), 1);
          items++;
        end
        tcur += longint'($urandom_range(0, 4)) <<< 16 | $urandom_range(0, 16'hFFFF);
      end
      tend = tcur + (longint'(3) <<< 16);
      nq = $urandom_range(3, 10);
      if (ph == 2) hold_receiver = 1;
      for (int q = 0; q < nq; q++) begin
        case ($urandom_range(0, 9))
          0: qtime = rand48();
          1: qtime = 48'(-($urandom_range(0, 1 << 20)));
          2: qtime = 48'(tend * $urandom_range(2, 40));
          default: qtime = 48'($urandom_range(0, int'(tend >>> 8)) * 256);
        endcase
        send_item(($urandom_range(0, 19) == 0) ? MODE_UNUSED : ttli_pkg::MODE_QUERY,
                  rand48(), 1'($urandom_range(0, 1)), qtime, 1);
        items++;
      end
    end

    // Drain, bounded.
    in_valid <= 0;
    waited = 0;
    while (pending_results.size() != 0 && waited < 200000) begin
      @(negedge clk);
      waited++;
    end
    repeat (400) @(negedge clk);
    if (mismatches == 0 && pending_results.size() == 0)
      $display("** timed_table_linear_interpolator: PASSED **");
    else
      $display("** timed_table_linear_interpolator: FAILED **");
    $finish;
  end
endmodule
`default_nettype wire
